>>> design/hex_spiral_index_to_coord_macros.svh
// Assertion macros for the hexagonal spiral coordinate block.
// Used by the port checker; no other dependencies.
`ifndef HEX_SPIRAL_INDEX_TO_COORD_MACROS_SVH
`define HEX_SPIRAL_INDEX_TO_COORD_MACROS_SVH

// Clocked property, switched off while reset is high
`define HSIC_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds through reset
`define HSIC_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/hsic_pkg.sv
// Shared widths, codes and controller/datapath bundles for the
// hexagonal spiral coordinate block. No dependencies.
package hsic_pkg;

   localparam int IN_W        = 17;
   localparam int COORD_W     = 9;
   localparam int K_W         = 8;   // ring number, at most 209
   localparam int SIX_K_W     = K_W + 3;
   localparam int SEG_W       = 3;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;
   localparam int ARITH_W     = K_W + 2;

   localparam logic [IN_W-1:0] MAX_INDEX = IN_W'(131071);

   // Side of the ring, in walk order after the diagonal run
   localparam logic [SEG_W-1:0] SEG_TOP       = 3'd0;
   localparam logic [SEG_W-1:0] SEG_LEFT      = 3'd1;
   localparam logic [SEG_W-1:0] SEG_LOW_LEFT  = 3'd2;
   localparam logic [SEG_W-1:0] SEG_BOTTOM    = 3'd3;
   localparam logic [SEG_W-1:0] SEG_RIGHT     = 3'd4;
   localparam logic [SEG_W-1:0] SEG_LAST      = 3'd5;

   typedef struct packed {
      logic load;
      logic ring_step;
      logic adjust;
      logic seg_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic ring_more;
      logic seg_more;
      logic out_free;
   } status_type;

endpackage

>>> design/hex_spiral_index_to_coord.sv
// Top level of the hexagonal spiral cell-number to axial-coordinate block.
// Depends on hsic_pkg, hsic_ctrl and hsic_dpath.
//
//   Channel | Dir | Payload
//   req_    | in  | tdata[16:0] cell_number
//   rsp_    | out | tdata[8:0] coord_x, tdata[17:9] coord_y
//
// One item passes from transfer to result through the ring search, one ring
// per cycle, an adjust step, the side search and the emit; the ring number
// is at most 209 and the side index at most 5.
// Reset clears the controller and the result valid; no clearing pass.
// A new item is taken while a result waits; a stalled result stalls the next.
module hex_spiral_index_to_coord (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [hsic_pkg::REQ_TDATA_W-1:0] req_tdata,   // [16:0] cell_number
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [hsic_pkg::RSP_TDATA_W-1:0] rsp_tdata    // [8:0] coord_x, [17:9] coord_y
);

   localparam int C_W = hsic_pkg::COORD_W;

   hsic_pkg::cmd_type    cmd;
   hsic_pkg::status_type status;
   logic signed [C_W-1:0] coord_x;
   logic signed [C_W-1:0] coord_y;

   hsic_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hsic_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cell_number (req_tdata[hsic_pkg::IN_W-1:0]),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .coord_x     (coord_x),
      .coord_y     (coord_y)
   );

   // Pack the result, zero padding on top
   assign rsp_tdata = {(hsic_pkg::RSP_TDATA_W - 2 * C_W)'(0), coord_y, coord_x};

endmodule

>>> design/hsic_ctrl.sv
// Sequencer for the spiral lookup: walks ring search, adjust, side search, emit.
// Depends on hsic_pkg.
module hsic_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  hsic_pkg::status_type status,
   output hsic_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RING = 3'd1;
   localparam logic [2:0] ST_ADJ  = 3'd2;
   localparam logic [2:0] ST_SEG  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == ST_IDLE) && !reset;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = ST_RING;
            end
         end
         ST_RING: begin
            if (status.ring_more) begin
               cmd.ring_step = 1'b1;
            end else begin
               state_in = ST_ADJ;
            end
         end
         ST_ADJ: begin
            cmd.adjust = 1'b1;
            state_in   = ST_SEG;
         end
         ST_SEG: begin
            if (status.seg_more) begin
               cmd.seg_step = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/hsic_dpath.sv
// Datapath for the spiral lookup: offset, ring and side registers,
// coordinate formation and the result register. Depends on hsic_pkg.
module hsic_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [hsic_pkg::IN_W-1:0]           cell_number,
   input  hsic_pkg::cmd_type                   cmd,
   output hsic_pkg::status_type                status,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic signed [hsic_pkg::COORD_W-1:0] coord_x,
   output logic signed [hsic_pkg::COORD_W-1:0] coord_y
);

   localparam int IN_W    = hsic_pkg::IN_W;
   localparam int K_W     = hsic_pkg::K_W;
   localparam int SIX_K_W = hsic_pkg::SIX_K_W;
   localparam int SEG_W   = hsic_pkg::SEG_W;
   localparam int A_W     = hsic_pkg::ARITH_W;
   localparam int C_W     = hsic_pkg::COORD_W;

   logic [IN_W-1:0]  pos_ff;      // offset within the current ring
   logic [K_W-1:0]   ring_ff;
   logic [SEG_W-1:0] seg_ff;
   logic             special_ff;  // origin answer
   logic             early_ff;    // on the diagonal run
   logic             rsp_valid_ff;
   logic signed [C_W-1:0] x_ff;
   logic signed [C_W-1:0] y_ff;

   logic [SIX_K_W-1:0] six_k;
   logic [K_W-1:0]     ring_m1;
   logic signed [A_W-1:0] ki;
   logic signed [A_W-1:0] ri;
   logic signed [A_W-1:0] x_calc;
   logic signed [A_W-1:0] y_calc;

   assign six_k   = (SIX_K_W'(ring_ff) << 2) + (SIX_K_W'(ring_ff) << 1);
   assign ring_m1 = ring_ff - K_W'(1);

   // Loop status for the controller
   assign status.ring_more = !special_ff && (pos_ff >= IN_W'(six_k));
   assign status.seg_more  = !special_ff && !early_ff && (pos_ff >= IN_W'(ring_ff));
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   // Step offset, ring and side
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pos_ff     <= cell_number - IN_W'(2);
         ring_ff    <= K_W'(1);
         seg_ff     <= hsic_pkg::SEG_TOP;
         early_ff   <= 1'b0;
         special_ff <= (cell_number <= IN_W'(1)) || (cell_number > hsic_pkg::MAX_INDEX);
      end else if (cmd.ring_step) begin
         pos_ff  <= pos_ff - IN_W'(six_k);
         ring_ff <= ring_ff + K_W'(1);
      end else if (cmd.adjust) begin
         if (pos_ff < IN_W'(ring_m1)) begin
            early_ff <= 1'b1;
         end else begin
            pos_ff <= pos_ff - IN_W'(ring_m1);
         end
      end else if (cmd.seg_step) begin
         pos_ff <= pos_ff - IN_W'(ring_ff);
         seg_ff <= seg_ff + SEG_W'(1);
      end
   end

   // Form coordinates from ring, side and remainder
   assign ki = A_W'(ring_ff);
   assign ri = A_W'(pos_ff[K_W-1:0]);

   always_comb begin
      x_calc = '0;
      y_calc = '0;
      if (special_ff) begin
         x_calc = '0;
         y_calc = '0;
      end else if (early_ff) begin
         x_calc = ki - A_W'(1) - ri;
         y_calc = A_W'(1) + ri;
      end else begin
         case (seg_ff)
            hsic_pkg::SEG_TOP: begin
               x_calc = -ri;
               y_calc = ki;
            end
            hsic_pkg::SEG_LEFT: begin
               x_calc = -ki;
               y_calc = ki - ri;
            end
            hsic_pkg::SEG_LOW_LEFT: begin
               x_calc = ri - ki;
               y_calc = -ri;
            end
            hsic_pkg::SEG_BOTTOM: begin
               x_calc = ri;
               y_calc = -ki;
            end
            hsic_pkg::SEG_RIGHT: begin
               x_calc = ki;
               y_calc = ri - ki;
            end
            default: begin
               x_calc = ki;
               y_calc = '0;
            end
         endcase
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         x_ff <= x_calc[C_W-1:0];
         y_ff <= y_calc[C_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign coord_x    = x_ff;
   assign coord_y    = y_ff;

endmodule

>>> design/hsic_checker.sv
// Port-level checker for hex_spiral_index_to_coord, bound to the top level.
// Depends on hsic_pkg and hex_spiral_index_to_coord_macros.svh.
`include "hex_spiral_index_to_coord_macros.svh"

module hsic_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [hsic_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int PAD_LO = 2 * hsic_pkg::COORD_W;

   // Result held steady while stalled
   `HSIC_ASSERT_RST(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "result changed while stalled")

   // Reset empties the result register
   `HSIC_ASSERT(a_rsp_reset, clock, reset |=> !rsp_tvalid, "result valid after reset")

   // One item at a time: intake closes after a transfer
   `HSIC_ASSERT_RST(a_req_busy, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "input taken while busy")

   // Padding above the coordinates stays zero
   `HSIC_ASSERT_RST(a_rsp_pad, clock, reset, rsp_tvalid |-> (rsp_tdata[hsic_pkg::RSP_TDATA_W-1:PAD_LO] == '0), "nonzero padding in result")

endmodule

bind hex_spiral_index_to_coord hsic_checker u_hsic_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> dv/testbench.sv
// Self-checking regression for hex_spiral_index_to_coord: streams cell numbers in,
// predicts each axial coordinate and checks every result transfer.
// Depends on hsic_pkg and the hex_spiral_index_to_coord RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IN_W          = hsic_pkg::IN_W;
   localparam int COORD_W       = hsic_pkg::COORD_W;
   localparam int SEG_W         = hsic_pkg::SEG_W;
   localparam int REQ_TDATA_W   = hsic_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W   = hsic_pkg::RSP_TDATA_W;
   localparam int CYCLE_LIMIT   = 2_500_000;
   localparam int HOLD_CYCLES   = 900;
   localparam int SETTLE_CYCLES = 250;
   localparam int MAX_RING      = 209;

   typedef struct {
      logic [IN_W-1:0]           cell_num;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
   } coord_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [16:0] cell_number
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;          // [8:0] coord_x, [17:9] coord_y

   coord_type coord_q[$];
   int     send_idle_pct  = 0;
   int     recv_stall_pct = 0;
   bit     hold_req       = 1'b0;
   int     hold_left      = 0;
   int     cycle_count    = 0;
   bit     failed         = 1'b0;

   hex_spiral_index_to_coord dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Walk the spiral ring by ring, then place the cell on its side
   function automatic coord_type locate_cell(logic [IN_W-1:0] cell_num);
      coord_type        c;
      int               n;
      int               k;
      int               first;
      int               p;
      int               q;
      int               r;
      int               x;
      int               y;
      logic [SEG_W-1:0] side;
      n = cell_num;
      x = 0;
      y = 0;
      if (n > 1 && n <= int'(hsic_pkg::MAX_INDEX)) begin
         k = 1;
         first = 2;
         while (n >= first + 6 * k) begin
            first += 6 * k;
            k++;
         end
         p = n - first;
         if (p < k - 1) begin
            x = k - 1 - p;
            y = 1 + p;
         end else begin
            q = p - (k - 1);
            side = SEG_W'(q / k);
            r = q % k;
            case (side)
               hsic_pkg::SEG_TOP: begin
                  x = -r;
                  y = k;
               end
               hsic_pkg::SEG_LEFT: begin
                  x = -k;
                  y = k - r;
               end
               hsic_pkg::SEG_LOW_LEFT: begin
                  x = -k + r;
                  y = -r;
               end
               hsic_pkg::SEG_BOTTOM: begin
                  x = r;
                  y = -k;
               end
               hsic_pkg::SEG_RIGHT: begin
                  x = k;
                  y = -k + r;
               end
               default: begin
                  x = k;
                  y = 0;
               end
            endcase
         end
      end
      c.cell_num = cell_num;
      c.coord_x  = x[COORD_W-1:0];
      c.coord_y  = y[COORD_W-1:0];
      return c;
   endfunction

   // Cell at offset pos from the start of ring k, clamped to the largest cell number
   function automatic logic [IN_W-1:0] ring_cell(int k, int pos);
      int n;
      n = 2 + 3 * k * (k - 1) + pos;
      if (n > int'(hsic_pkg::MAX_INDEX))
         n = int'(hsic_pkg::MAX_INDEX);
      return IN_W'(n);
   endfunction

   // Offer one cell number, hold it until the transfer, then maybe go idle
   task automatic send_cell(logic [IN_W-1:0] cell_num);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(cell_num);
      do @(posedge clock); while (!req_tready);
      coord_q = {coord_q, locate_cell(cell_num)};
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
   endtask

   // Lower valid and wait until every pending coordinate has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (coord_q.size() == 0);
      @(posedge clock);
   endtask

   // Centre, cell zero, every cell of ring one, part of ring two, ring ends, largest cells
   task automatic test_directed_cells();
      int cells[$];
      cells = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 12, 14, 16, 18, 19, 37, 38,
                131070, 131071, 65536, 43690, 87381};
      foreach (cells[i])
         send_cell(IN_W'(cells[i]));
   endtask

   // Well-formed walks: pick a ring, land on a side start, corner or random spot
   task automatic test_ring_walks(int count);
      int k;
      int pos;
      for (int i = 0; i < count; i++) begin
         k = ($urandom_range(9) == 0) ? $urandom_range(MAX_RING, 1) : $urandom_range(40, 1);
         case ($urandom_range(3))
            0: pos = 0;
            1: pos = 6 * k - 1;
            2: pos = (k - 1) + k * $urandom_range(5) + ($urandom_range(1) ? k - 1 : 0);
            default: pos = $urandom_range(6 * k - 1);
         endcase
         send_cell(ring_cell(k, pos));
      end
   endtask

   // Loose cell numbers, mostly small, some over the full field
   task automatic test_random_cells(int count);
      logic [IN_W-1:0] cell_num;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0)
            cell_num = IN_W'($urandom_range(int'(hsic_pkg::MAX_INDEX)));
         else
            cell_num = IN_W'($urandom_range(2000));
         send_cell(cell_num);
      end
   endtask

   // Stall the result side for a long stretch while cells keep coming, then drain
   task automatic test_long_backpressure();
      hold_req = 1'b1;
      for (int i = 0; i < 12; i++)
         send_cell(IN_W'($urandom_range(300)));
      drain_results();
   endtask

   // Result-side ready: long hold-off on request, otherwise random stalls
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare each result transfer with the oldest predicted coordinate
   always @(posedge clock) begin
      coord_type                 want;
      logic signed [COORD_W-1:0] got_x;
      logic signed [COORD_W-1:0] got_y;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_x = rsp_tdata[COORD_W-1:0];
         got_y = rsp_tdata[2*COORD_W-1:COORD_W];
         if (coord_q.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d", $time, got_x, got_y);
            failed = 1'b1;
         end else begin
            want = coord_q.pop_front();
            if (got_x !== want.coord_x) begin
               $display("%0t: cell %0d coord_x expected %0d actual %0d",
                        $time, want.cell_num, want.coord_x, got_x);
               failed = 1'b1;
            end
            if (got_y !== want.coord_y) begin
               $display("%0t: cell %0d coord_y expected %0d actual %0d",
                        $time, want.cell_num, want.coord_y, got_y);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hex_spiral_index_to_coord regression: fail");
         $finish;
      end
   end

   initial begin
      int idle_pct[4];
      int stall_pct[4];
      idle_pct  = '{0, 66, 0, 38};
      stall_pct = '{0, 0, 66, 38};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cells();
      test_long_backpressure();

      // Run each idling mix over its own phase, draining in between
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = idle_pct[ph];
         recv_stall_pct = stall_pct[ph];
         test_ring_walks(250);
         test_random_cells(180);
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (!failed && coord_q.size() == 0)
         $display("hex_spiral_index_to_coord regression: pass");
      else
         $display("hex_spiral_index_to_coord regression: fail");
      $finish;
   end

endmodule
